@@ hdl/wtbs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wall temperature solver package
// Widths, constants, micro-op codes and the micro-program table shared by the
// datapath, the sequencer and the top level.
// ----------------------------------------------------------------------------
package wtbs_pkg;

   // field widths
   localparam int EM_W    = 17;
   localparam int RW_W    = 24;
   localparam int HC_W    = 20;
   localparam int QI_W    = 32;
   localparam int TEMP_W  = 22;
   localparam int SIGMA_W = 32;
   localparam int STAT_W  = 2;

   // wide accumulator built from limbs, processed one limb per cycle
   localparam int LIMB_W     = 32;
   localparam int NUM_LIMBS  = 6;
   localparam int ACC_W      = LIMB_W * NUM_LIMBS;
   localparam int PROD_W     = 2 * LIMB_W;
   localparam int LIMB_IDX_W = $clog2(NUM_LIMBS);
   localparam logic [LIMB_IDX_W-1:0] LIMB_LAST = LIMB_IDX_W'(NUM_LIMBS - 1);

   // stored coefficient widths (em*rw*sigma, hc*rw + 2^32, right hand side)
   localparam int ERS_W    = EM_W + RW_W + SIGMA_W;
   localparam int HR_W     = HC_W + RW_W + 1;
   localparam int TERM_W   = 160;
   localparam int HR_ONE_POS = 32;

   // alignment of each term to units of 2^-128
   localparam int HR_SHIFT = 86;
   localparam int QI_SHIFT = 80;
   localparam int TB_SHIFT = 118;

   // search constants
   localparam logic [TEMP_W-1:0] T_START = TEMP_W'(512000);
   localparam logic [TEMP_W-1:0] TOL_LSB = TEMP_W'(10);
   localparam int CNT_W = 5;
   localparam logic [CNT_W-1:0] MAX_SCALE  = CNT_W'(5);
   localparam logic [CNT_W-1:0] MAX_BISECT = CNT_W'(20);
   localparam logic [SIGMA_W-1:0] SIGMA_RESET = SIGMA_W'(15960685);

   // result status codes
   localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NO_BRACKET = 2'd1;
   localparam logic [STAT_W-1:0] STAT_LIMIT      = 2'd2;

   // datapath micro-ops
   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_NOP      = 4'd0;
   localparam logic [OP_W-1:0] OP_LOAD_EM  = 4'd1;
   localparam logic [OP_W-1:0] OP_LOAD_HC  = 4'd2;
   localparam logic [OP_W-1:0] OP_LOAD_ERS = 4'd3;
   localparam logic [OP_W-1:0] OP_MUL      = 4'd4;
   localparam logic [OP_W-1:0] OP_SAVE_ERS = 4'd5;
   localparam logic [OP_W-1:0] OP_SAVE_HR  = 4'd6;
   localparam logic [OP_W-1:0] OP_TERM_SET = 4'd7;
   localparam logic [OP_W-1:0] OP_TERM_ADD = 4'd8;
   localparam logic [OP_W-1:0] OP_ADD_HR   = 4'd9;
   localparam logic [OP_W-1:0] OP_DECIDE   = 4'd10;

   // multiplier operand selects
   localparam int SEL_W = 3;
   localparam logic [SEL_W-1:0] SEL_NONE  = 3'd0;
   localparam logic [SEL_W-1:0] SEL_RW    = 3'd1;
   localparam logic [SEL_W-1:0] SEL_SIGMA = 3'd2;
   localparam logic [SEL_W-1:0] SEL_TG    = 3'd3;
   localparam logic [SEL_W-1:0] SEL_QI    = 3'd4;
   localparam logic [SEL_W-1:0] SEL_T     = 3'd5;

   // micro-program: coefficient setup, then one quartic evaluation
   localparam int PC_W = 5;
   localparam logic [PC_W-1:0] PC_EVAL   = 5'd13;
   localparam logic [PC_W-1:0] PC_DECIDE = 5'd19;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [SEL_W-1:0] sel;
   } uop_type;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [SEL_W-1:0] sel;
      logic             first;
   } cmd_type;

   typedef struct packed {
      logic              valid;
      logic [TEMP_W-1:0] temp;
      logic [STAT_W-1:0] status;
   } res_type;

   function automatic uop_type uop_at(input logic [PC_W-1:0] pc);
      uop_type u;
      u = '{op: OP_DECIDE, sel: SEL_NONE};
      case (pc)
         5'd0:  u = '{op: OP_LOAD_EM,  sel: SEL_NONE};
         5'd1:  u = '{op: OP_MUL,      sel: SEL_RW};
         5'd2:  u = '{op: OP_MUL,      sel: SEL_SIGMA};
         5'd3:  u = '{op: OP_SAVE_ERS, sel: SEL_NONE};
         5'd4:  u = '{op: OP_LOAD_HC,  sel: SEL_NONE};
         5'd5:  u = '{op: OP_MUL,      sel: SEL_RW};
         5'd6:  u = '{op: OP_SAVE_HR,  sel: SEL_NONE};
         5'd7:  u = '{op: OP_MUL,      sel: SEL_TG};
         5'd8:  u = '{op: OP_TERM_SET, sel: SEL_NONE};
         5'd9:  u = '{op: OP_LOAD_EM,  sel: SEL_NONE};
         5'd10: u = '{op: OP_MUL,      sel: SEL_RW};
         5'd11: u = '{op: OP_MUL,      sel: SEL_QI};
         5'd12: u = '{op: OP_TERM_ADD, sel: SEL_NONE};
         PC_EVAL: u = '{op: OP_LOAD_ERS, sel: SEL_NONE};
         5'd14: u = '{op: OP_MUL,      sel: SEL_T};
         5'd15: u = '{op: OP_MUL,      sel: SEL_T};
         5'd16: u = '{op: OP_MUL,      sel: SEL_T};
         5'd17: u = '{op: OP_ADD_HR,   sel: SEL_NONE};
         5'd18: u = '{op: OP_MUL,      sel: SEL_T};
         PC_DECIDE: u = '{op: OP_DECIDE, sel: SEL_NONE};
         default: u = '{op: OP_DECIDE, sel: SEL_NONE};
      endcase
      return u;
   endfunction

endpackage

@@ hdl/wall_temperature_bisection_solver.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wall temperature bisection solver
// Solves t*(em*rw*sigma*t^3 + hc*rw + 1) = em*rw*qi + hc*rw*tg + tb for the
// wall surface temperature by bracketing from 500 K and then bisecting.
// ----------------------------------------------------------------------------
// One word is solved at a time. After a request word is accepted, req_ready
// stays low until the result word has been moved into the response register.
// All multiplies run on a single 32x32 multiply-accumulate that walks a
// 192-bit accumulator one 32-bit limb per cycle. A solve runs a coefficient
// setup, then one evaluation of the quartic per search step (four
// limb-serial multiplies, a wide add, a load and a decision). A solve
// takes at least 6 and at most 26 evaluations by the scaling and
// bisection step limits. The response register lets a new request start
// while a finished result still waits on rsp_ready.
// Status 0 means converged to within 10 LSB, 1 means five scalings by 0.75
// or 1.5 did not bracket the root (the scaled t is returned), 2 means twenty
// bisection steps ran out (the current midpoint is returned).
// csr_wdata writes the radiation constant; write it only while idle.
// ----------------------------------------------------------------------------
module wall_temperature_bisection_solver (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [wtbs_pkg::EM_W-1:0]    req_emissivity,
   input  logic [wtbs_pkg::RW_W-1:0]    req_wall_resistance,
   input  logic [wtbs_pkg::HC_W-1:0]    req_convection_coefficient,
   input  logic [wtbs_pkg::QI_W-1:0]    req_incident_flux,
   input  logic [wtbs_pkg::TEMP_W-1:0]  req_gas_temperature,
   input  logic [wtbs_pkg::TEMP_W-1:0]  req_back_temperature,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [wtbs_pkg::TEMP_W-1:0]  rsp_wall_temperature,
   output logic [wtbs_pkg::STAT_W-1:0]  rsp_solve_status,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [wtbs_pkg::SIGMA_W-1:0] csr_wdata
);
   import wtbs_pkg::*;

   // captured request word
   logic [EM_W-1:0]    em_ff;
   logic [RW_W-1:0]    rw_ff;
   logic [HC_W-1:0]    hc_ff;
   logic [QI_W-1:0]    qi_ff;
   logic [TEMP_W-1:0]  tg_ff;
   logic [TEMP_W-1:0]  tb_ff;

   // radiation constant register
   logic [SIGMA_W-1:0] sigma_ff;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [TEMP_W-1:0]  rsp_temp_ff;
   logic [STAT_W-1:0]  rsp_stat_ff;

   cmd_type           cmd;
   res_type           seq_res;
   logic [TEMP_W-1:0] cur_t;
   logic              busy;
   logic              gt, lt;
   logic              req_take;
   logic              res_take;

   // accept a request only while the sequencer is idle
   assign req_ready = !busy;
   assign req_take  = req_valid && req_ready;

   // move the finished word into the response register once it is free
   assign res_take = seq_res.valid && (!rsp_valid_ff || rsp_ready);

   // the register is to be written only while idle; not enforced here, so always take the write
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sigma_ff <= SIGMA_RESET;
      end else if (csr_valid && csr_ready) begin
         sigma_ff <= csr_wdata;
      end
   end

   // hold the request fields for the whole solve
   always_ff @(posedge clock) begin
      if (req_take) begin
         em_ff <= req_emissivity;
         rw_ff <= req_wall_resistance;
         hc_ff <= req_convection_coefficient;
         qi_ff <= req_incident_flux;
         tg_ff <= req_gas_temperature;
         tb_ff <= req_back_temperature;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (res_take) begin
         rsp_temp_ff <= seq_res.temp;
         rsp_stat_ff <= seq_res.status;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_wall_temperature = rsp_temp_ff;
   assign rsp_solve_status     = rsp_stat_ff;

   wtbs_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .start_i (req_take),
      .take_i  (res_take),
      .gt_i    (gt),
      .lt_i    (lt),
      .cmd_o   (cmd),
      .t_o     (cur_t),
      .busy_o  (busy),
      .res_o   (seq_res)
   );

   wtbs_datapath u_datapath (
      .clock   (clock),
      .cmd_i   (cmd),
      .em_i    (em_ff),
      .rw_i    (rw_ff),
      .hc_i    (hc_ff),
      .qi_i    (qi_ff),
      .tg_i    (tg_ff),
      .tb_i    (tb_ff),
      .sigma_i (sigma_ff),
      .t_i     (cur_t),
      .gt_o    (gt),
      .lt_o    (lt)
   );

   // one word in flight: an accepted request closes the input at once
   assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req_ready)
      else $error("request accepted while a solve is running");

   // a new response only follows a running solve
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(busy))
      else $error("response raised without a solve in progress");

   // a finished result is held until the response register takes it
   assert property (@(posedge clock) disable iff (reset)
      (seq_res.valid && !res_take) |=> (seq_res.valid && $stable(seq_res.temp)))
      else $error("finished result dropped before it was taken");

   // the response register never reports an unknown status code
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_solve_status == STAT_OK || rsp_solve_status == STAT_NO_BRACKET
                     || rsp_solve_status == STAT_LIMIT))
      else $error("bad solve status");

endmodule

@@ hdl/wtbs_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wall temperature solver datapath
// Wide accumulator with one shared 32x32 multiply-accumulate, limb serial,
// plus the coefficient registers, wide adder and the f(t) versus term compare.
// ----------------------------------------------------------------------------
module wtbs_datapath (
   input  logic                         clock,
   input  wtbs_pkg::cmd_type            cmd_i,
   input  logic [wtbs_pkg::EM_W-1:0]    em_i,
   input  logic [wtbs_pkg::RW_W-1:0]    rw_i,
   input  logic [wtbs_pkg::HC_W-1:0]    hc_i,
   input  logic [wtbs_pkg::QI_W-1:0]    qi_i,
   input  logic [wtbs_pkg::TEMP_W-1:0]  tg_i,
   input  logic [wtbs_pkg::TEMP_W-1:0]  tb_i,
   input  logic [wtbs_pkg::SIGMA_W-1:0] sigma_i,
   input  logic [wtbs_pkg::TEMP_W-1:0]  t_i,
   output logic                         gt_o,
   output logic                         lt_o
);
   import wtbs_pkg::*;

   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [LIMB_W-1:0] carry_ff, carry_in;
   logic [ERS_W-1:0]  ers_ff, ers_in;
   logic [HR_W-1:0]   hr_ff, hr_in;
   logic [TERM_W-1:0] term_ff, term_in;

   logic [LIMB_W-1:0] operand;
   logic [LIMB_W-1:0] carry_use;
   logic [PROD_W-1:0] prod;

   always_comb begin
      case (cmd_i.sel)
         SEL_RW:    operand = LIMB_W'(rw_i);
         SEL_SIGMA: operand = LIMB_W'(sigma_i);
         SEL_TG:    operand = LIMB_W'(tg_i);
         SEL_QI:    operand = LIMB_W'(qi_i);
         SEL_T:     operand = LIMB_W'(t_i);
         default:   operand = '0;
      endcase
   end

   // low limb times operand plus carry of the previous limb
   assign carry_use = cmd_i.first ? '0 : carry_ff;
   assign prod = PROD_W'(acc_ff[LIMB_W-1:0]) * PROD_W'(operand) + PROD_W'(carry_use);

   always_comb begin
      acc_in   = acc_ff;
      carry_in = carry_ff;
      ers_in   = ers_ff;
      hr_in    = hr_ff;
      term_in  = term_ff;
      case (cmd_i.op)
         OP_LOAD_EM:  acc_in = ACC_W'(em_i);
         OP_LOAD_HC:  acc_in = ACC_W'(hc_i);
         OP_LOAD_ERS: acc_in = ACC_W'(ers_ff);
         OP_MUL: begin
            // rotate: the new limb enters at the top
            acc_in   = {prod[LIMB_W-1:0], acc_ff[ACC_W-1:LIMB_W]};
            carry_in = prod[PROD_W-1:LIMB_W];
         end
         OP_SAVE_ERS: ers_in = acc_ff[ERS_W-1:0];
         OP_SAVE_HR:  hr_in  = acc_ff[HR_W-1:0] + (HR_W'(1) << HR_ONE_POS);
         OP_TERM_SET: term_in = (TERM_W'(acc_ff) << HR_SHIFT) + (TERM_W'(tb_i) << TB_SHIFT);
         OP_TERM_ADD: term_in = term_ff + (TERM_W'(acc_ff) << QI_SHIFT);
         OP_ADD_HR:   acc_in  = acc_ff + (ACC_W'(hr_ff) << HR_SHIFT);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      carry_ff <= carry_in;
      ers_ff   <= ers_in;
      hr_ff    <= hr_in;
      term_ff  <= term_in;
   end

   assign gt_o = acc_ff > ACC_W'(term_ff);
   assign lt_o = acc_ff < ACC_W'(term_ff);

endmodule

@@ hdl/wtbs_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wall temperature solver sequencer
// Steps the micro-program, counts multiply limbs and runs the bracketing and
// bisection decisions on the sign of f(t) - term.
// ----------------------------------------------------------------------------
module wtbs_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start_i,
   input  logic                        take_i,
   input  logic                        gt_i,
   input  logic                        lt_i,
   output wtbs_pkg::cmd_type           cmd_o,
   output logic [wtbs_pkg::TEMP_W-1:0] t_o,
   output logic                        busy_o,
   output wtbs_pkg::res_type           res_o
);
   import wtbs_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   localparam logic [1:0] PH_FIRST  = 2'd0;
   localparam logic [1:0] PH_DOWN   = 2'd1;
   localparam logic [1:0] PH_UP     = 2'd2;
   localparam logic [1:0] PH_BISECT = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [1:0]            phase_ff, phase_in;
   logic [PC_W-1:0]       pc_ff, pc_in;
   logic [LIMB_IDX_W-1:0] limb_ff, limb_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [TEMP_W-1:0]     t_ff, t_in, t1_ff, t1_in, t2_ff, t2_in;
   logic [TEMP_W-1:0]     temp_ff, temp_in;
   logic [STAT_W-1:0]     stat_ff, stat_in;
   uop_type               uop;

   function automatic logic [TEMP_W-1:0] scale_down(input logic [TEMP_W-1:0] t);
      logic [TEMP_W+1:0] s;
      s = {2'b00, t} + {1'b0, t, 1'b0};
      return TEMP_W'(s >> 2);
   endfunction

   function automatic logic [TEMP_W-1:0] scale_up(input logic [TEMP_W-1:0] t);
      logic [TEMP_W+1:0] s;
      s = {2'b00, t} + {1'b0, t, 1'b0};
      return TEMP_W'(s >> 1);
   endfunction

   function automatic logic [TEMP_W-1:0] midpoint(input logic [TEMP_W-1:0] a,
                                                  input logic [TEMP_W-1:0] b);
      logic [TEMP_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return TEMP_W'(s >> 1);
   endfunction

   assign uop = uop_at(pc_ff);

   always_comb begin
      logic [TEMP_W-1:0] b1, b2, mid;
      logic              fin;
      b1       = t1_ff;
      b2       = t2_ff;
      mid      = '0;
      fin      = 1'b0;
      state_in = state_ff;
      phase_in = phase_ff;
      pc_in    = pc_ff;
      limb_in  = limb_ff;
      cnt_in   = cnt_ff;
      t_in     = t_ff;
      t1_in    = t1_ff;
      t2_in    = t2_ff;
      temp_in  = temp_ff;
      stat_in  = stat_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start_i) begin
               state_in = ST_RUN;
               phase_in = PH_FIRST;
               pc_in    = '0;
               limb_in  = '0;
               cnt_in   = '0;
               t_in     = T_START;
            end
         end
         ST_RUN: begin
            if (uop.op == OP_MUL) begin
               if (limb_ff == LIMB_LAST) begin
                  limb_in = '0;
                  pc_in   = pc_ff + PC_W'(1);
               end else begin
                  limb_in = limb_ff + LIMB_IDX_W'(1);
               end
            end else if (uop.op == OP_DECIDE) begin
               case (phase_ff)
                  PH_FIRST: begin
                     cnt_in = CNT_W'(1);
                     if (gt_i) begin
                        phase_in = PH_DOWN;
                        t2_in    = t_ff;
                        t_in     = scale_down(t_ff);
                     end else begin
                        phase_in = PH_UP;
                        t1_in    = t_ff;
                        t_in     = scale_up(t_ff);
                     end
                  end
                  PH_DOWN: begin
                     if (gt_i) begin
                        if (cnt_ff == MAX_SCALE) begin
                           fin     = 1'b1;
                           temp_in = t_ff;
                           stat_in = STAT_NO_BRACKET;
                        end else begin
                           cnt_in = cnt_ff + CNT_W'(1);
                           t2_in  = t_ff;
                           t_in   = scale_down(t_ff);
                        end
                     end else begin
                        phase_in = PH_BISECT;
                        cnt_in   = CNT_W'(1);
                        t1_in    = t_ff;
                        t_in     = midpoint(t_ff, t2_ff);
                     end
                  end
                  PH_UP: begin
                     if (lt_i) begin
                        if (cnt_ff == MAX_SCALE) begin
                           fin     = 1'b1;
                           temp_in = t_ff;
                           stat_in = STAT_NO_BRACKET;
                        end else begin
                           cnt_in = cnt_ff + CNT_W'(1);
                           t1_in  = t_ff;
                           t_in   = scale_up(t_ff);
                        end
                     end else begin
                        phase_in = PH_BISECT;
                        cnt_in   = CNT_W'(1);
                        t2_in    = t_ff;
                        t_in     = midpoint(t1_ff, t_ff);
                     end
                  end
                  default: begin
                     // shrink the bracket around the midpoint just evaluated
                     if (gt_i) begin
                        b2 = t_ff;
                     end else begin
                        b1 = t_ff;
                     end
                     mid   = midpoint(b1, b2);
                     t1_in = b1;
                     t2_in = b2;
                     t_in  = mid;
                     if (mid - b1 <= TOL_LSB) begin
                        fin     = 1'b1;
                        temp_in = mid;
                        stat_in = STAT_OK;
                     end else if (cnt_ff == MAX_BISECT) begin
                        fin     = 1'b1;
                        temp_in = mid;
                        stat_in = STAT_LIMIT;
                     end else begin
                        cnt_in = cnt_ff + CNT_W'(1);
                     end
                  end
               endcase
               if (fin) begin
                  state_in = ST_HOLD;
               end else begin
                  pc_in = PC_EVAL;
               end
            end else begin
               pc_in = pc_ff + PC_W'(1);
            end
         end
         ST_HOLD: begin
            if (take_i) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      phase_ff <= phase_in;
      pc_ff    <= pc_in;
      limb_ff  <= limb_in;
      cnt_ff   <= cnt_in;
      t_ff     <= t_in;
      t1_ff    <= t1_in;
      t2_ff    <= t2_in;
      temp_ff  <= temp_in;
      stat_ff  <= stat_in;
   end

   always_comb begin
      cmd_o.op    = (state_ff == ST_RUN) ? uop.op : OP_NOP;
      cmd_o.sel   = uop.sel;
      cmd_o.first = (limb_ff == '0);
   end

   assign t_o          = t_ff;
   assign busy_o       = (state_ff != ST_IDLE);
   assign res_o.valid  = (state_ff == ST_HOLD);
   assign res_o.temp   = temp_ff;
   assign res_o.status = stat_ff;

endmodule
